[hdl/fat12_cluster_chain_sector_walker_top_assert.svh]
// Assertion macros for the FAT12 cluster chain sector walker top level.
// Needs clk_i and rst_ni in the scope of the module that includes it.
`ifndef FAT12_CLUSTER_CHAIN_SECTOR_WALKER_TOP_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_SECTOR_WALKER_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define FAT12W_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define FAT12W_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fat12w_pkg.sv]
// Shared types and constants for the FAT12 cluster chain sector walker.
// Used by the register block, controller, datapath and top level.
package fat12w_pkg;

  localparam int unsigned FAT_BYTES_DEF = 8192;
  localparam int unsigned LBA_W         = 32;
  localparam int unsigned CL_W          = 12;
  localparam int unsigned SPC_W         = 8;
  localparam int unsigned SIC_W         = 7;
  localparam int unsigned OFF_W         = 13;
  localparam int unsigned BYTE_W        = 8;

  localparam logic [CL_W-1:0]  END_MARK = 12'hFF8;
  localparam logic [SPC_W-1:0] SPC_MAX  = 8'd128;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_OPEN = 2'd1,
    FUNC_ADV  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic {
    REG_SPC = 1'b0,
    REG_DSL = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_POS  = 2'd1,
    RES_FILE = 2'd2,
    RES_END  = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REDUCE,
    ST_RD_LO,
    ST_RD_HI,
    ST_FOLLOW,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic      cap;
    logic      wr_fat;
    logic      open;
    logic      root_inc;
    logic      sic_inc;
    logic      load_off;
    logic      reduce;
    logic      rd_hi;
    logic      cap_lo;
    logic      follow;
    logic      mul;
    logic      set_kind;
    res_kind_e kind;
    logic      emit;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  open_root;
    logic  root_mode;
    logic  at_end;
    logic  wrap;
    logic  off_big;
    logic  next_end;
    logic  out_free;
  } dp_status_t;

endpackage

[hdl/fat12w_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module fat12w_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fat12w_regs.sv]
// Configuration registers behind the APB-style port.
// Depends on fat12w_pkg for widths and register indexes.
module fat12w_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [fat12w_pkg::SPC_W-1:0]  spc_eff_o,
  output logic [fat12w_pkg::LBA_W-1:0]  dsl_o
);
  import fat12w_pkg::*;

  logic [SPC_W-1:0] spc_q, spc_d;
  logic [LBA_W-1:0] dsl_q, dsl_d;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  // Decode register writes
  always_comb begin
    spc_d = spc_q;
    dsl_d = dsl_q;
    if (wr_en) begin
      case (idx)
        REG_SPC: spc_d = pwdata[SPC_W-1:0];
        REG_DSL: dsl_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= 8'd1;
      dsl_q <= '0;
    end else begin
      spc_q <= spc_d;
      dsl_q <= dsl_d;
    end
  end

  // Read back stored values
  always_comb begin
    case (idx)
      REG_SPC: prdata = {{(32-SPC_W){1'b0}}, spc_q};
      REG_DSL: prdata = dsl_q;
      default: prdata = '0;
    endcase
  end

  // Clamp cluster size to 1..128
  always_comb begin
    if (spc_q == '0) begin
      spc_eff_o = 8'd1;
    end else if (spc_q > SPC_MAX) begin
      spc_eff_o = SPC_MAX;
    end else begin
      spc_eff_o = spc_q;
    end
  end

  assign dsl_o = dsl_q;

endmodule

[hdl/fat12w_ctrl.sv]
// Sequencer for the sector walker: decodes each word and steps the datapath.
// Depends on fat12w_pkg for the state, command and status types.
module fat12w_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  fat12w_pkg::dp_status_t  status_i,
  output fat12w_pkg::ctrl_cmd_t   cmd_o
);
  import fat12w_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.func)
          FUNC_OPEN: state_d = status_i.open_root ? ST_EMIT : ST_MUL;
          FUNC_ADV: begin
            if (status_i.root_mode || status_i.at_end) begin
              state_d = ST_EMIT;
            end else if (status_i.wrap) begin
              state_d = ST_REDUCE;
            end else begin
              state_d = ST_MUL;
            end
          end
          default: state_d = ST_EMIT;
        endcase
      end
      ST_REDUCE: begin
        if (!status_i.off_big) state_d = ST_RD_LO;
      end
      ST_RD_LO:  state_d = ST_RD_HI;
      ST_RD_HI:  state_d = ST_FOLLOW;
      ST_FOLLOW: state_d = status_i.next_end ? ST_EMIT : ST_MUL;
      ST_MUL:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = RES_ZERO;
    in_ready_o = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: cmd_o.cap = in_valid_i;
      ST_DECODE: begin
        cmd_o.set_kind = 1'b1;
        case (status_i.func)
          FUNC_LOAD: cmd_o.wr_fat = 1'b1;
          FUNC_OPEN: begin
            cmd_o.open = 1'b1;
            cmd_o.kind = status_i.open_root ? RES_POS : RES_FILE;
          end
          FUNC_ADV: begin
            if (status_i.root_mode) begin
              cmd_o.root_inc = 1'b1;
              cmd_o.kind     = RES_POS;
            end else if (status_i.at_end) begin
              cmd_o.kind = RES_END;
            end else if (status_i.wrap) begin
              cmd_o.load_off = 1'b1;
            end else begin
              cmd_o.sic_inc = 1'b1;
              cmd_o.kind    = RES_FILE;
            end
          end
          default: ;
        endcase
      end
      ST_REDUCE: cmd_o.reduce = status_i.off_big;
      ST_RD_LO:  cmd_o.rd_hi = 1'b0;
      ST_RD_HI: begin
        cmd_o.rd_hi  = 1'b1;
        cmd_o.cap_lo = 1'b1;
      end
      ST_FOLLOW: begin
        cmd_o.follow   = 1'b1;
        cmd_o.set_kind = 1'b1;
        cmd_o.kind     = status_i.next_end ? RES_END : RES_FILE;
      end
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_EMIT: cmd_o.emit = status_i.out_free;
      default: ;
    endcase
  end

endmodule

[hdl/fat12w_dp.sv]
// Datapath of the sector walker: chain state, FAT image, address math, output word.
// Depends on fat12w_pkg and fat12w_ram.
module fat12w_dp #(
  parameter int unsigned FAT_BYTES = fat12w_pkg::FAT_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fat12w_pkg::ctrl_cmd_t         cmd_i,
  output fat12w_pkg::dp_status_t        status_o,
  input  logic [fat12w_pkg::SPC_W-1:0]  spc_eff_i,
  input  logic [fat12w_pkg::LBA_W-1:0]  dsl_i,
  input  fat12w_pkg::func_e             func_i,
  input  logic [fat12w_pkg::OFF_W-1:0]  table_address_i,
  input  logic [fat12w_pkg::BYTE_W-1:0] table_byte_i,
  input  logic [fat12w_pkg::CL_W-1:0]   first_cluster_i,
  input  logic [fat12w_pkg::LBA_W-1:0]  root_start_lba_i,
  input  logic                          open_root_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fat12w_pkg::LBA_W-1:0]  sector_lba_o,
  output logic                          end_of_chain_o,
  output logic [fat12w_pkg::CL_W-1:0]   cluster_now_o
);
  import fat12w_pkg::*;

  localparam int unsigned AW        = (FAT_BYTES > 1) ? $clog2(FAT_BYTES) : 1;
  localparam logic [31:0] FatBytesW = 32'(FAT_BYTES);

  // Captured input word
  func_e             func_q;
  logic              open_root_q;
  logic [OFF_W-1:0]  tab_addr_q;
  logic [BYTE_W-1:0] tab_byte_q;
  logic [CL_W-1:0]   first_cl_q;
  logic [LBA_W-1:0]  root_lba_q;

  // Chain state
  logic [LBA_W-1:0] pos_q, pos_d;
  logic [SIC_W-1:0] sic_q, sic_d;
  logic             root_q, root_d;

  // Work registers
  logic [OFF_W-1:0]  off_q;
  logic [BYTE_W-1:0] lo_q;
  logic [LBA_W-1:0]  prod_q;
  res_kind_e         kind_q;

  // Output word
  logic             out_valid_q, out_valid_d;
  logic [LBA_W-1:0] out_lba_q;
  logic             out_eoc_q;
  logic [CL_W-1:0]  out_cl_q;

  logic [CL_W-1:0]       cl;
  logic [SPC_W-1:0]      sic_nx;
  logic [31:0]           off_ext, off_hi, tab_ext;
  logic [AW-1:0]         raddr;
  logic [BYTE_W-1:0]     rdata;
  logic                  we;
  logic [2*BYTE_W-1:0]   word;
  logic [CL_W-1:0]       next_cl;
  logic [LBA_W-1:0]      cl_m2;
  logic [LBA_W+SPC_W-1:0] prod_full;
  logic [LBA_W-1:0]      lba_sel;

  assign cl      = pos_q[CL_W-1:0];
  assign sic_nx  = {1'b0, sic_q} + 8'd1;
  assign off_ext = 32'(off_q);
  assign off_hi  = ((off_ext + 32'd1) == FatBytesW) ? 32'd0 : off_ext + 32'd1;
  assign tab_ext = 32'(tab_addr_q);
  assign raddr   = cmd_i.rd_hi ? off_hi[AW-1:0] : off_ext[AW-1:0];
  assign we      = cmd_i.wr_fat && (tab_ext < FatBytesW);
  assign word    = {rdata, lo_q};
  assign next_cl = cl[0] ? word[15:4] : word[11:0];
  assign cl_m2   = 32'(cl) - 32'd2;
  assign prod_full = cl_m2 * spc_eff_i;

  fat12w_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FAT_BYTES),
    .AW    (AW)
  ) u_fat (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tab_ext[AW-1:0]),
    .wdata_i (tab_byte_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Status to the controller
  always_comb begin
    status_o.func      = func_q;
    status_o.open_root = open_root_q;
    status_o.root_mode = root_q;
    status_o.at_end    = (cl >= END_MARK);
    status_o.wrap      = (sic_nx >= spc_eff_i);
    status_o.off_big   = (off_ext >= FatBytesW);
    status_o.next_end  = (next_cl >= END_MARK);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Hold the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      func_q      <= func_i;
      open_root_q <= open_root_i;
      tab_addr_q  <= table_address_i;
      tab_byte_q  <= table_byte_i;
      first_cl_q  <= first_cluster_i;
      root_lba_q  <= root_start_lba_i;
    end
  end

  // Update chain state
  always_comb begin
    pos_d  = pos_q;
    sic_d  = sic_q;
    root_d = root_q;
    if (cmd_i.open) begin
      sic_d  = '0;
      root_d = open_root_q;
      pos_d  = open_root_q ? root_lba_q : 32'(first_cl_q);
    end else if (cmd_i.root_inc) begin
      pos_d = pos_q + 32'd1;
    end else if (cmd_i.sic_inc) begin
      sic_d = sic_nx[SIC_W-1:0];
    end else if (cmd_i.follow) begin
      sic_d = '0;
      pos_d = 32'(next_cl);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sic_q  <= '0;
      root_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      sic_q  <= sic_d;
      root_q <= root_d;
    end
  end

  // FAT offset, low byte, product and result kind
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_off) begin
      off_q <= 13'({1'b0, cl}) + 13'(cl[CL_W-1:1]);
    end else if (cmd_i.reduce) begin
      off_q <= OFF_W'(off_ext - FatBytesW);
    end
    if (cmd_i.cap_lo) lo_q <= rdata;
    if (cmd_i.mul) prod_q <= prod_full[LBA_W-1:0];
    if (cmd_i.set_kind) kind_q <= cmd_i.kind;
  end

  // Select the sector address
  always_comb begin
    case (kind_q)
      RES_POS:  lba_sel = pos_q;
      RES_FILE: lba_sel = dsl_i + prod_q + 32'(sic_q);
      default:  lba_sel = '0;
    endcase
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_lba_q <= lba_sel;
      out_eoc_q <= (kind_q == RES_END);
      out_cl_q  <= root_q ? '0 : cl;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sector_lba_o   = out_lba_q;
  assign end_of_chain_o = out_eoc_q;
  assign cluster_now_o  = out_cl_q;

endmodule

[hdl/fat12_cluster_chain_sector_walker_top.sv]
// FAT12 cluster chain sector walker: one word in, one result word out, one item at a time.
// Load, unused, open root and advance in root or past the end go from decode to the result;
// open file and advance in a cluster pass the registered multiply; advance across a cluster
// reduces the FAT offset per image wrap, reads two bytes from the single-read FAT RAM and
// multiplies unless the new entry ends the chain; input is taken again once the result is
// registered. Reset: asynchronous active low; clears chain, FSM, valid and config; FAT kept.
module fat12_cluster_chain_sector_walker_top #(
  parameter int unsigned FAT_BYTES = fat12w_pkg::FAT_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: table_address[12:0], table_byte[20:13], first_cluster[32:21],
  //        root_start_lba[64:33], zero pad[71:65]
  input  logic [71:0] s_axis_tdata,
  // tuser: func[1:0], open_root[2]
  input  logic [2:0]  s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: sector_lba[31:0], cluster_now[43:32], zero pad[47:44]
  output logic [47:0] m_axis_tdata,
  // tuser: end_of_chain[0]
  output logic [0:0]  m_axis_tuser
);
  import fat12w_pkg::*;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [SPC_W-1:0] spc_eff;
  logic [LBA_W-1:0] dsl;
  logic [LBA_W-1:0] sector_lba;
  logic             end_of_chain;
  logic [CL_W-1:0]  cluster_now;

  fat12w_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .spc_eff_o (spc_eff),
    .dsl_o     (dsl)
  );

  fat12w_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fat12w_dp #(
    .FAT_BYTES (FAT_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .spc_eff_i        (spc_eff),
    .dsl_i            (dsl),
    .func_i           (func_e'(s_axis_tuser[1:0])),
    .table_address_i  (s_axis_tdata[12:0]),
    .table_byte_i     (s_axis_tdata[20:13]),
    .first_cluster_i  (s_axis_tdata[32:21]),
    .root_start_lba_i (s_axis_tdata[64:33]),
    .open_root_i      (s_axis_tuser[2]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .sector_lba_o     (sector_lba),
    .end_of_chain_o   (end_of_chain),
    .cluster_now_o    (cluster_now)
  );

  // Pack the result word
  assign m_axis_tdata = {4'd0, cluster_now, sector_lba};
  assign m_axis_tuser = end_of_chain;

`include "fat12_cluster_chain_sector_walker_top_assert.svh"

  // One word in flight: ready drops right after an accept
  `FAT12W_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a word while busy")

  // A stalled result keeps the pending emit waiting
  `FAT12W_ASSERT_SAME(a_emit_waits, m_axis_tvalid && !m_axis_tready, !cmd.emit, "emit while output still full")

  // End of chain always carries a zero sector address
  `FAT12W_ASSERT_SAME(a_end_zero_lba, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0, "end of chain with nonzero sector")

endmodule

[tb/testbench.sv]
// Testbench for the FAT12 cluster chain sector walker top level.
// Drives the command stream and the APB-style register port, predicts every result word
// in-line and compares it against the result stream. Depends on fat12w_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fat12w_pkg::*;

  localparam int unsigned FAT_SIZE     = FAT_BYTES_DEF;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned DRAIN_LIMIT  = 4000;

  // One command word and one result word, unpacked into their fields
  typedef struct packed {
    func_e       func;
    logic [12:0] tbl_addr;
    logic [7:0]  tbl_byte;
    logic [11:0] first_cl;
    logic [31:0] root_lba;
    logic        open_root;
  } walk_cmd_t;

  typedef struct packed {
    logic [31:0] lba;
    logic        eoc;
    logic [11:0] cluster;
  } walk_res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // Shadow of the walker: FAT image, chain position and register copies
  bit   [7:0]  fat_shadow [FAT_SIZE];
  bit          fat_known  [FAT_SIZE];
  logic [31:0] chain_pos      = '0;
  logic [6:0]  sec_in_cl      = '0;
  logic        in_root        = 1'b0;
  logic [7:0]  spc_cfg        = 8'd1;
  logic [31:0] data_start_cfg = '0;

  walk_res_t expected_sectors [$];
  int        errors     = 0;
  int        item_count = 0;
  bit        burst_mode = 1'b0;

  fat12_cluster_chain_sector_walker_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Clamp the cluster size: zero acts as one, anything above 128 as 128
  function automatic logic [31:0] eff_spc();
    if (spc_cfg == 8'd0) return 32'd1;
    if (spc_cfg > SPC_MAX) return {24'd0, SPC_MAX};
    return {24'd0, spc_cfg};
  endfunction

  // First sector of a cluster; clusters below two wrap around 2^32
  function automatic logic [31:0] cluster_base(input logic [11:0] cl);
    return data_start_cfg + ({20'd0, cl} - 32'd2) * eff_spc();
  endfunction

  // Byte offset of a packed 12-bit entry; the image is 2^13 bytes, so truncation wraps it
  function automatic logic [12:0] entry_offset(input logic [11:0] cl);
    logic [31:0] off;
    off = ({20'd0, cl} * 32'd3) / 32'd2;
    return off[12:0];
  endfunction

  function automatic logic [11:0] fat_entry(input logic [11:0] cl);
    logic [12:0] off;
    logic [15:0] pair;
    off  = entry_offset(cl);
    pair = {fat_shadow[off + 13'd1], fat_shadow[off]};
    return cl[0] ? pair[15:4] : pair[11:0];
  endfunction

  // True when the next advance leaves the current cluster and reads the FAT
  function automatic bit will_follow();
    return !in_root && chain_pos[11:0] < END_MARK &&
           ({25'd0, sec_in_cl} + 32'd1 >= eff_spc());
  endfunction

  // Apply one command word to the shadow and return the result word it produces
  function automatic walk_res_t next_sector_result(input walk_cmd_t cmd);
    walk_res_t   res;
    logic [11:0] cl;
    logic [31:0] step;
    res = '0;
    case (cmd.func)
      FUNC_LOAD: begin
        fat_shadow[cmd.tbl_addr] = cmd.tbl_byte;
        fat_known[cmd.tbl_addr]  = 1'b1;
      end
      FUNC_OPEN: begin
        sec_in_cl = '0;
        in_root   = cmd.open_root;
        if (cmd.open_root) begin
          chain_pos = cmd.root_lba;
          res.lba   = chain_pos;
        end else begin
          chain_pos = {20'd0, cmd.first_cl};
          res.lba   = cluster_base(cmd.first_cl);
        end
      end
      FUNC_ADV: begin
        if (in_root) begin
          chain_pos = chain_pos + 32'd1;
          res.lba   = chain_pos;
        end else begin
          cl = chain_pos[11:0];
          if (cl >= END_MARK) begin
            // already past the end: nothing moves
            res.eoc = 1'b1;
          end else begin
            step = {25'd0, sec_in_cl} + 32'd1;
            if (step >= eff_spc()) begin
              step = '0;
              cl   = fat_entry(cl);
            end
            sec_in_cl = step[6:0];
            chain_pos = {20'd0, cl};
            if (cl >= END_MARK) res.eoc = 1'b1;
            else res.lba = cluster_base(cl) + {25'd0, sec_in_cl};
          end
        end
      end
      default: ;
    endcase
    res.cluster = in_root ? 12'd0 : chain_pos[11:0];
    return res;
  endfunction

  function automatic walk_cmd_t random_cmd(input func_e f);
    walk_cmd_t c;
    c.func      = f;
    c.tbl_addr  = 13'($urandom);
    c.tbl_byte  = 8'($urandom);
    c.first_cl  = 12'($urandom);
    c.root_lba  = $urandom;
    c.open_root = 1'($urandom);
    return c;
  endfunction

  // Mostly regular clusters, now and then one of the two below the data area
  function automatic logic [11:0] pick_cluster();
    if ($urandom_range(9) == 0) return 12'($urandom_range(0, 1));
    return 12'($urandom_range(2, 12'hFF7));
  endfunction

  function automatic logic [31:0] pick_lba();
    int unsigned sel;
    sel = $urandom_range(3);
    if (sel == 0) return 32'd0;
    if (sel == 1) return 32'hFFFF_FFFF - $urandom_range(0, 7);
    return $urandom;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // Send one command word, with a random gap ahead of it; predict once it is taken
  task automatic send_word(input walk_cmd_t cmd);
    int unsigned gap;
    gap = 0;
    while (!burst_mode && gap < 20 && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, cmd.root_lba, cmd.first_cl, cmd.tbl_byte, cmd.tbl_addr};
    s_axis_tuser  <= {cmd.open_root, cmd.func};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_sectors.push_back(next_sector_result(cmd));
    if (cmd.func != FUNC_NONE) item_count++;
  endtask

  // Drop valid and hold until every expected word has come back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_sectors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SPC) spc_cfg = value[7:0];
    else data_start_cfg = value;
  endtask

  task automatic load_byte(input logic [12:0] addr, input logic [7:0] value);
    walk_cmd_t c;
    c          = random_cmd(FUNC_LOAD);
    c.tbl_addr = addr;
    c.tbl_byte = value;
    send_word(c);
  endtask

  task automatic open_file(input logic [11:0] cl);
    walk_cmd_t c;
    c           = random_cmd(FUNC_OPEN);
    c.open_root = 1'b0;
    c.first_cl  = cl;
    send_word(c);
  endtask

  task automatic open_root_dir(input logic [31:0] lba);
    walk_cmd_t c;
    c           = random_cmd(FUNC_OPEN);
    c.open_root = 1'b1;
    c.root_lba  = lba;
    send_word(c);
  endtask

  // Advance one sector; load any FAT byte the step reads that was never written
  task automatic advance_sector();
    logic [12:0] off;
    if (will_follow()) begin
      off = entry_offset(chain_pos[11:0]);
      if (!fat_known[off]) load_byte(off, 8'($urandom));
      if (!fat_known[off + 13'd1]) load_byte(off + 13'd1, 8'($urandom));
    end
    send_word(random_cmd(FUNC_ADV));
  endtask

  // Write a 12-bit entry as two byte loads, keeping the neighbor's nibble
  task automatic set_entry(input logic [11:0] cl, input logic [11:0] value);
    logic [12:0] off;
    logic [7:0]  lo;
    logic [7:0]  hi;
    off = entry_offset(cl);
    lo  = fat_shadow[off];
    hi  = fat_shadow[off + 13'd1];
    if (cl[0]) begin
      lo = {value[3:0], lo[3:0]};
      hi = value[11:4];
    end else begin
      lo = value[7:0];
      hi = {hi[7:4], value[11:8]};
    end
    load_byte(off, lo);
    load_byte(off + 13'd1, hi);
  endtask

  // Build a chain of the given length ending in an end mark, open it and walk it
  task automatic walk_file_chain(input int hops, input bit full);
    logic [11:0] cl;
    logic [11:0] first;
    logic [11:0] nxt;
    int          steps;
    cl    = pick_cluster();
    first = cl;
    for (int i = 0; i < hops; i++) begin
      nxt = (i == hops - 1) ? 12'($urandom_range(12'hFF8, 12'hFFF)) : pick_cluster();
      set_entry(cl, nxt);
      cl = nxt;
    end
    open_file(first);
    if (full) steps = hops * int'(eff_spc()) + $urandom_range(0, 2);
    else steps = $urandom_range(1, hops * int'(eff_spc()));
    repeat (steps) advance_sector();
  endtask

  task automatic walk_root(input int steps);
    open_root_dir(pick_lba());
    repeat (steps) advance_sector();
  endtask

  task automatic noise_item();
    func_e f;
    f = func_e'($urandom_range(0, 3));
    if (f == FUNC_ADV) advance_sector();
    else send_word(random_cmd(f));
  endtask

  // Reset register values, field extremes and every corner of the chain walk
  task automatic test_directed_edges();
    walk_cmd_t c;
    c      = '1;
    c.func = FUNC_NONE;
    send_word(c);
    load_byte(13'd0, 8'hFF);
    load_byte(13'h1FFF, 8'h00);
    // root directory LBA wraps past the top
    open_root_dir(32'hFFFF_FFFF);
    advance_sector();
    advance_sector();
    // cluster zero: address wraps, its entry 0xFFF ends the chain, then stays ended
    load_byte(13'd1, 8'h0F);
    open_file(12'd0);
    advance_sector();
    advance_sector();
    // opening an end cluster still gives an address
    open_file(12'hFFF);
    advance_sector();
    // cluster one links to cluster zero through an odd entry
    load_byte(13'd2, 8'h00);
    open_file(12'd1);
    advance_sector();
    advance_sector();
    // highest regular cluster, smallest end mark
    set_entry(12'hFF7, END_MARK);
    open_file(12'hFF7);
    advance_sector();
    c      = '0;
    c.func = FUNC_NONE;
    send_word(c);
  endtask

  // Cluster sizes out of range and at the limits, data start at both ends
  task automatic test_cluster_sizes();
    logic [7:0] sizes [4];
    sizes = '{8'd0, 8'd128, 8'd255, 8'd3};
    foreach (sizes[i]) begin
      write_reg(REG_SPC, {24'd0, sizes[i]});
      write_reg(REG_DSL, (i % 2 == 1) ? 32'hFFFF_FFFF : 32'd0);
      walk_file_chain(2, 1'b1);
      walk_file_chain(1, 1'b0);
    end
  endtask

  task automatic test_root_walks();
    repeat (12) begin
      walk_root($urandom_range(1, 8));
      if ($urandom_range(1) == 1) walk_file_chain(1, 1'b1);
    end
  endtask

  // Both sides run without any idle cycle
  task automatic test_burst_chains();
    burst_mode = 1'b1;
    write_reg(REG_SPC, 32'd2);
    repeat (10) walk_file_chain($urandom_range(1, 4), 1'b1);
    walk_root(20);
    burst_mode = 1'b0;
  endtask

  // Phases of random settings until the run reaches its word total, each with chain walks,
  // root walks and stray words
  task automatic test_random_mix();
    int          target;
    int unsigned sel;
    target = int'(RANDOM_ITEMS);
    while (item_count < target) begin
      if ($urandom_range(99) < 85) write_reg(REG_SPC, $urandom_range(0, 6));
      else write_reg(REG_SPC, $urandom_range(7, 40));
      write_reg(REG_DSL, pick_lba());
      repeat (20) begin
        if (item_count >= target) break;
        sel = $urandom_range(99);
        if (sel < 55) walk_file_chain($urandom_range(1, 5), $urandom_range(3) != 0);
        else if (sel < 70) walk_root($urandom_range(1, 6));
        else noise_item();
      end
    end
  endtask

  // Compare each result word against the oldest prediction; stall at random
  always @(posedge clk_i) begin : result_check
    walk_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sectors.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual %h %h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        want = expected_sectors.pop_front();
        check_field("sector_lba", want.lba, m_axis_tdata[31:0]);
        check_field("cluster_now", {20'd0, want.cluster}, {20'd0, m_axis_tdata[43:32]});
        check_field("end_of_chain", {31'd0, want.eoc}, {31'd0, m_axis_tuser[0]});
      end
    end
    m_axis_tready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    int wait_cycles;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_cluster_sizes();
    test_root_walks();
    test_burst_chains();
    test_random_mix();
    // drain the result stream, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_sectors.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (16) @(posedge clk_i);
    if (expected_sectors.size() != 0) begin
      $display("%0t: result words missing, expected %0d more, actual 0",
               $time, expected_sectors.size());
      errors += expected_sectors.size();
    end
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
